/* rtl/core/laplacian_edge_filter_3x3_core_macros.svh */
// assertion macros for the laplacian edge filter core
// used by the back end; expects clk and rst_n in the including scope
`ifndef LAPLACIAN_EDGE_FILTER_3X3_CORE_MACROS_SVH
`define LAPLACIAN_EDGE_FILTER_3X3_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LEF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LEF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LEF_ASSERT_IMP(lbl, ante, cons, msg)
`define LEF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/lef_pkg.sv */
// shared types and constants of the laplacian edge filter core
// no dependencies
package lef_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_OUT_W    = 12;
    localparam int COL_OUT_W    = 10;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_SIZE     = 3;
    localparam int PIX_MAX      = 255;

    typedef struct packed {
        logic [PIX_W-1:0] gray_pixel;
        logic             frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]     result_pixel;
        logic [ROW_OUT_W-1:0] result_row;
        logic [COL_OUT_W-1:0] result_column;
        logic                 last_of_run;
        logic                 frame_done;
    } result_t;

    // classification of one pixel by the front end
    typedef struct packed {
        logic emit_upper;  // releases the result one line up
        logic border;      // that result is a border pixel
        logic last_row;    // also releases its own result
        logic frame_end;   // bottom-right pixel of the frame
    } item_flags_t;

endpackage

/* rtl/core/lef_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module lef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, read-first
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lef_front.sv */
// front end: configuration registers, raster position counters and pixel classification
// depends on lef_pkg
module lef_front
    import lef_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  pixel_in_t                     pixel,
    output logic                          item_valid,
    input  logic                          item_ready,
    output logic [PIX_W-1:0]              item_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]  item_col,
    output logic [$clog2(MAX_HEIGHT)-1:0] item_row,
    output item_flags_t                   item_flags
);

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WB-1:0] width_reg, width_next;
    logic [HB-1:0] height_reg, height_next;
    logic [CB-1:0] col_reg, col_next;
    logic [RB-1:0] row_reg, row_next;

    logic [31:0]   width_raw, height_raw;
    logic [WB-1:0] width_sat;
    logic [HB-1:0] height_sat;

    logic          accept;
    logic [CB-1:0] col_start, c;
    logic [RB-1:0] row_start, r;
    logic [HB-1:0] row_step, row_ext, r_plus;
    logic [WB-1:0] c_plus;
    logic          col_wrap, row_wrap;

    assign cfg_ready   = 1'b1;
    assign accept      = pixel_valid && pixel_ready;
    assign item_valid  = pixel_valid;
    assign pixel_ready = item_ready;

    // saturate register writes into the supported range
    always_comb
    begin
        width_raw  = 32'(cfg_data[WIDTH_REG_W-1:0]);
        height_raw = 32'(cfg_data[HEIGHT_REG_W-1:0]);
        if (width_raw < 32'(MIN_SIZE))
            width_sat = WB'(MIN_SIZE);
        else if (width_raw > 32'(MAX_WIDTH))
            width_sat = WB'(MAX_WIDTH);
        else
            width_sat = WB'(width_raw);
        if (height_raw < 32'(MIN_SIZE))
            height_sat = HB'(MIN_SIZE);
        else if (height_raw > 32'(MAX_HEIGHT))
            height_sat = HB'(MAX_HEIGHT);
        else
            height_sat = HB'(height_raw);
    end

    // register decoder
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = width_sat;
                REG_IMAGE_HEIGHT: height_next = height_sat;
                default:          ;
            endcase
        end
    end

    // position of the incoming pixel, with restart and wrap after a size change
    always_comb
    begin
        col_start = pixel.frame_start ? '0 : col_reg;
        row_start = pixel.frame_start ? '0 : row_reg;
        row_step  = HB'(row_start) + HB'(1);
        if (WB'(col_start) >= width_reg)
        begin
            c       = '0;
            row_ext = row_step;
        end
        else
        begin
            c       = col_start;
            row_ext = HB'(row_start);
        end
        r        = (row_ext >= height_reg) ? '0 : row_ext[RB-1:0];
        c_plus   = WB'(c) + WB'(1);
        r_plus   = HB'(r) + HB'(1);
        col_wrap = c_plus >= width_reg;
        row_wrap = r_plus >= height_reg;
    end

    // classification handed to the back end
    always_comb
    begin
        item_pix              = pixel.gray_pixel;
        item_col              = c;
        item_row              = r;
        item_flags.emit_upper = r != '0;
        item_flags.border     = (r == RB'(1)) || (c == '0) || col_wrap;
        item_flags.last_row   = row_wrap;
        item_flags.frame_end  = row_wrap && col_wrap;
    end

    // counters advance past the accepted pixel
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : r_plus[RB-1:0];
            end
            else
            begin
                col_next = c_plus[CB-1:0];
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WB'(W_RST);
            height_reg <= HB'(H_RST);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

/* rtl/core/lef_queue.sv */
// short first-in first-out queue in flops between front and back end
// depends on lef_pkg only through the caller's data layout
module lef_queue #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg != NW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/lef_back.sv */
// back end: line stores, neighbor bypass, laplacian arithmetic and result beats
// depends on lef_pkg, lef_ram and the assertion macro header
`include "laplacian_edge_filter_3x3_core_macros.svh"
module lef_back
    import lef_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [PIX_W-1:0]              item_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]  item_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0] item_row,
    input  item_flags_t                   item_flags,
    output logic                          result_valid,
    input  logic                          result_ready,
    output result_t                       result
);

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int LAP_W = 12;

    function automatic logic [PIX_W-1:0] clamp_pixel(input logic signed [LAP_W-1:0] s);
        logic [PIX_W-1:0] v;
        if (s < 0)
            v = '0;
        else if (s > LAP_W'(PIX_MAX))
            v = PIX_W'(PIX_MAX);
        else
            v = s[PIX_W-1:0];
        return v;
    endfunction

    logic pop, s1_adv, s2_free, last_beat, out_accept;

    // stage one: descriptor aligned with the line store read data
    logic              s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [CB-1:0]     s1_col_reg;
    logic [CB-1:0]     s1_right_reg;
    logic [RB-1:0]     s1_row_reg;
    item_flags_t       s1_flags_reg;

    // last line store write, for read-after-write bypass
    logic              lw_valid_reg;
    logic [CB-1:0]     lw_col_reg;
    logic [PIX_W-1:0]  lw_pix_reg;
    logic [PIX_W-1:0]  lw_mid_reg;

    // left neighbor of the window
    logic [PIX_W-1:0]  left_reg;

    // stage two: up to two results of one pixel
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_sel_reg, s2_sel_next;
    logic              s2_two_reg;
    result_t           s2_a_reg, s2_b_reg;

    logic [CB-1:0]     right_addr;
    logic [PIX_W-1:0]  mid_q, right_q, up_q;
    logic [PIX_W-1:0]  old_mid, old_up, right;
    logic              hit_center, hit_right;
    logic signed [LAP_W-1:0] lap;
    result_t           res_a, res_b;

    // handshakes between stages
    assign last_beat  = !s2_two_reg || s2_sel_reg;
    assign out_accept = result_valid && result_ready;
    assign s2_free    = !s2_valid_reg || (result_ready && last_beat);
    assign s1_adv     = s1_valid_reg && (!s1_flags_reg.emit_upper || s2_free);
    assign item_ready = !s1_valid_reg || s1_adv;
    assign pop        = item_valid && item_ready;
    assign right_addr = item_col + CB'(1);

    // middle line, center read
    lef_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_center (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (pop),
        .raddr (item_col),
        .rdata (mid_q)
    );

    // middle line copy for the right neighbor read
    lef_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_right (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (pop),
        .raddr (right_addr),
        .rdata (right_q)
    );

    // upper line
    lef_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (old_mid),
        .re    (pop),
        .raddr (item_col),
        .rdata (up_q)
    );

    // bypass the write of the previous pixel, which lands on the read edge
    always_comb
    begin
        hit_center = lw_valid_reg && (lw_col_reg == s1_col_reg);
        hit_right  = lw_valid_reg && (lw_col_reg == s1_right_reg);
        old_mid    = hit_center ? lw_pix_reg : mid_q;
        old_up     = hit_center ? lw_mid_reg : up_q;
        right      = hit_right ? lw_pix_reg : right_q;
    end

    // four-neighbor laplacian of the center one line up
    always_comb
    begin
        lap = $signed(LAP_W'(old_up)) + $signed(LAP_W'(s1_pix_reg))
            + $signed(LAP_W'(left_reg)) + $signed(LAP_W'(right))
            - $signed(LAP_W'({old_mid, 2'b00}));
    end

    // result payloads
    always_comb
    begin
        res_a.result_pixel  = s1_flags_reg.border ? old_mid : clamp_pixel(lap);
        res_a.result_row    = ROW_OUT_W'(s1_row_reg - RB'(1));
        res_a.result_column = COL_OUT_W'(s1_col_reg);
        res_a.last_of_run   = !s1_flags_reg.last_row;
        res_a.frame_done    = 1'b0;
        res_b.result_pixel  = s1_pix_reg;
        res_b.result_row    = ROW_OUT_W'(s1_row_reg);
        res_b.result_column = COL_OUT_W'(s1_col_reg);
        res_b.last_of_run   = 1'b1;
        res_b.frame_done    = s1_flags_reg.frame_end;
    end

    // stage control next state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        s2_sel_next   = s2_sel_reg;
        if (s1_adv && s1_flags_reg.emit_upper)
        begin
            s2_valid_next = 1'b1;
            s2_sel_next   = 1'b0;
        end
        else if (out_accept && last_beat)
        begin
            s2_valid_next = 1'b0;
            s2_sel_next   = 1'b0;
        end
        else if (out_accept)
        begin
            s2_sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_sel_reg   <= 1'b0;
            s2_two_reg   <= 1'b0;
            lw_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s2_sel_reg   <= s2_sel_next;
            if (s1_adv && s1_flags_reg.emit_upper)
                s2_two_reg <= s1_flags_reg.last_row;
            if (s1_adv)
            begin
                lw_valid_reg <= 1'b1;
                left_reg     <= old_mid;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_pix_reg   <= item_pix;
            s1_col_reg   <= item_col;
            s1_right_reg <= right_addr;
            s1_row_reg   <= item_row;
            s1_flags_reg <= item_flags;
        end
        if (s1_adv)
        begin
            lw_col_reg <= s1_col_reg;
            lw_pix_reg <= s1_pix_reg;
            lw_mid_reg <= old_mid;
        end
        if (s1_adv && s1_flags_reg.emit_upper)
        begin
            s2_a_reg <= res_a;
            s2_b_reg <= res_b;
        end
    end

    // output beat
    assign result_valid = s2_valid_reg;
    assign result       = s2_sel_reg ? s2_b_reg : s2_a_reg;

    `LEF_ASSERT_IMP(a_sel_needs_two, s2_valid_reg && s2_sel_reg, s2_two_reg,
        "second result selected for a pixel with a single result")
    `LEF_ASSERT_NXT(a_bottom_follows, out_accept && s2_two_reg && !s2_sel_reg,
        result_valid && s2_sel_reg, "bottom line result did not follow its upper result")
    `LEF_ASSERT_IMP(a_done_is_last, result_valid && result.frame_done, result.last_of_run,
        "frame end result not marked last of run")

endmodule

/* rtl/core/laplacian_edge_filter_3x3_core.sv */
// top level of the four-neighbor laplacian edge filter core
// depends on lef_pkg, lef_front, lef_queue, lef_back
//
// Gray pixels enter in raster order, one beat each; every pixel of line r
// releases the filtered result of the same column in line r-1, and pixels of
// the last line also release their own unchanged value right after it, so the
// first line gives no beats and the last line gives two per pixel. Sustained
// rate is one pixel per clock outside the last line while result_ready stays
// high; a last-line pixel holds the back end until its second result beat is
// taken, since the single result port carries one result at a time. The front
// end tracks position and classifies pixels, a four-entry queue decouples it
// from the back end, which holds the line stores (MAX_WIDTH bytes each, middle
// line kept twice for the right-neighbor read) and needs no clearing pass after
// reset. Width and height writes saturate to 3..MAX_WIDTH and 3..MAX_HEIGHT
// and should only be made while the core is idle.
module laplacian_edge_filter_3x3_core
    import lef_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  pixel_in_t              pixel,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result
);

    localparam int CB      = $clog2(MAX_WIDTH);
    localparam int RB      = $clog2(MAX_HEIGHT);
    localparam int FLAGS_W = $bits(item_flags_t);
    localparam int DESC_W  = PIX_W + CB + RB + FLAGS_W;
    localparam int Q_DEPTH = 4;

    logic              fe_valid, fe_ready;
    logic [PIX_W-1:0]  fe_pix;
    logic [CB-1:0]     fe_col;
    logic [RB-1:0]     fe_row;
    item_flags_t       fe_flags;

    logic              be_valid, be_ready;
    logic [PIX_W-1:0]  be_pix;
    logic [CB-1:0]     be_col;
    logic [RB-1:0]     be_row;
    item_flags_t       be_flags;

    logic [DESC_W-1:0] q_in, q_out;

    // position tracking and classification
    lef_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .item_valid  (fe_valid),
        .item_ready  (fe_ready),
        .item_pix    (fe_pix),
        .item_col    (fe_col),
        .item_row    (fe_row),
        .item_flags  (fe_flags)
    );

    // descriptor packing across the queue
    assign q_in = {fe_pix, fe_col, fe_row, fe_flags};
    assign {be_pix, be_col, be_row, be_flags} = q_out;

    lef_queue #(
        .DATA_W (DESC_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (q_in),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (q_out)
    );

    // line stores, arithmetic and result beats
    lef_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (be_valid),
        .item_ready   (be_ready),
        .item_pix     (be_pix),
        .item_col     (be_col),
        .item_row     (be_row),
        .item_flags   (be_flags),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
